>>> hdl/pfk_pkg.sv
// Shared types, constants and CORDIC arctangent table for the planar 3R kinematics block.
package pfk_pkg;

    localparam int LENGTH_W      = 16;
    localparam int OUT_W         = 19;
    localparam int CFG_INDEX_W   = 2;
    localparam int CORDIC_STAGES = 28;
    localparam int ANGLE32_W     = 32;
    localparam int TRIG_W        = 33;
    localparam int TRIG_SHIFT    = 30;
    localparam int PROD_W        = LENGTH_W + 1 + TRIG_W;
    localparam int SUM_W         = PROD_W + 2;

    typedef logic [LENGTH_W-1:0]        length_t;
    typedef logic signed [TRIG_W-1:0]   trig_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [SUM_W-1:0]    sum_t;
    typedef logic signed [OUT_W-1:0]    coord_t;

    typedef struct packed {
        trig_t x;
        trig_t y;
        trig_t z;
    } rot_t;

    typedef struct packed {
        trig_t cos_val;
        trig_t sin_val;
    } unit_t;

    localparam logic [CFG_INDEX_W-1:0] REG_LENGTH_BASE     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LENGTH_SHOULDER = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LENGTH_ELBOW    = 2'd2;

    localparam length_t LENGTH_BASE_RESET     = 16'd4096;
    localparam length_t LENGTH_SHOULDER_RESET = 16'd2048;
    localparam length_t LENGTH_ELBOW_RESET    = 16'd1024;

    localparam trig_t CORDIC_GAIN = 33'sd652032874;

    localparam logic [ANGLE32_W-1:0] ATAN_TABLE [CORDIC_STAGES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005
    };

endpackage

>>> hdl/pfk_cordic_stage.sv
// One registered CORDIC rotation micro-step.
module pfk_cordic_stage
    import pfk_pkg::*;
#(
    parameter int STAGE = 0
)
(
    input  logic clk,
    input  rot_t stage_in,
    output rot_t stage_out
);

    localparam trig_t ATAN_STEP = trig_t'({1'b0, ATAN_TABLE[STAGE]});

    trig_t x_in;
    trig_t y_in;
    trig_t z_in;
    rot_t  stage_next;
    rot_t  stage_reg;

    always_comb
    begin
        x_in = stage_in.x;
        y_in = stage_in.y;
        z_in = stage_in.z;
        if (!z_in[TRIG_W-1])
        begin
            stage_next.x = x_in - (y_in >>> STAGE);
            stage_next.y = y_in + (x_in >>> STAGE);
            stage_next.z = z_in - ATAN_STEP;
        end
        else
        begin
            stage_next.x = x_in + (y_in >>> STAGE);
            stage_next.y = y_in - (x_in >>> STAGE);
            stage_next.z = z_in + ATAN_STEP;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign stage_out = stage_reg;

endmodule

>>> hdl/pfk_sincos.sv
// Pipelined sine and cosine of one binary angle: quadrant fold, CORDIC chain, unfold.
module pfk_sincos
    import pfk_pkg::*;
#(
    parameter int ANGLE_BITS = 16
)
(
    input  logic                  clk,
    input  logic [ANGLE_BITS-1:0] angle,
    output unit_t                 unit
);

    logic [ANGLE32_W-1:0]   angle32;
    logic                   flip;
    logic [ANGLE32_W-1:0]   folded;
    trig_t                  z_reg;
    logic [CORDIC_STAGES:0] flip_reg;
    rot_t                   chain [CORDIC_STAGES+1];
    rot_t                   last;
    unit_t                  unit_next;
    unit_t                  unit_reg;

    assign angle32 = {angle, {(ANGLE32_W-ANGLE_BITS){1'b0}}};
    assign flip    = angle32[ANGLE32_W-1] ^ angle32[ANGLE32_W-2];
    assign folded  = angle32 ^ {flip, {(ANGLE32_W-1){1'b0}}};

    always_ff @(posedge clk)
    begin
        z_reg    <= trig_t'({folded[ANGLE32_W-1], folded});
        flip_reg <= {flip_reg[CORDIC_STAGES-1:0], flip};
    end

    assign chain[0] = '{x: CORDIC_GAIN, y: '0, z: z_reg};

    for (genvar k = 0; k < CORDIC_STAGES; k++)
    begin : g_stage
        pfk_cordic_stage #(
            .STAGE(k)
        ) u_stage (
            .clk      (clk),
            .stage_in (chain[k]),
            .stage_out(chain[k+1])
        );
    end

    assign last = chain[CORDIC_STAGES];

    always_comb
    begin
        if (flip_reg[CORDIC_STAGES])
        begin
            unit_next.cos_val = -last.x;
            unit_next.sin_val = -last.y;
        end
        else
        begin
            unit_next.cos_val = last.x;
            unit_next.sin_val = last.y;
        end
    end

    always_ff @(posedge clk)
    begin
        unit_reg <= unit_next;
    end

    assign unit = unit_reg;

endmodule

>>> hdl/pfk_combine.sv
// Link-length scaling, summation and rounding to the Q6.12 tip coordinates.
module pfk_combine
    import pfk_pkg::*;
(
    input  logic    clk,
    input  unit_t   units   [3],
    input  length_t lengths [3],
    output coord_t  tip_x,
    output coord_t  tip_y
);

    localparam sum_t ROUND_BIAS =
        {{(SUM_W-TRIG_SHIFT){1'b0}}, 1'b1, {(TRIG_SHIFT-1){1'b0}}};

    prod_t  prod_x_next [3];
    prod_t  prod_y_next [3];
    prod_t  prod_x_reg  [3];
    prod_t  prod_y_reg  [3];
    sum_t   sum_x;
    sum_t   sum_y;
    coord_t tip_x_reg;
    coord_t tip_y_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod_x_next[i] = $signed({1'b0, lengths[i]}) * units[i].cos_val;
            prod_y_next[i] = $signed({1'b0, lengths[i]}) * units[i].sin_val;
        end
    end

    assign sum_x = SUM_W'(prod_x_reg[0]) + SUM_W'(prod_x_reg[1])
                 + SUM_W'(prod_x_reg[2]) + ROUND_BIAS;
    assign sum_y = SUM_W'(prod_y_reg[0]) + SUM_W'(prod_y_reg[1])
                 + SUM_W'(prod_y_reg[2]) + ROUND_BIAS;

    always_ff @(posedge clk)
    begin
        prod_x_reg <= prod_x_next;
        prod_y_reg <= prod_y_next;
        tip_x_reg  <= sum_x[TRIG_SHIFT+OUT_W-1:TRIG_SHIFT];
        tip_y_reg  <= sum_y[TRIG_SHIFT+OUT_W-1:TRIG_SHIFT];
    end

    assign tip_x = tip_x_reg;
    assign tip_y = tip_y_reg;

endmodule

>>> hdl/planar_three_link_forward_kinematics.sv
// Top level of the planar three-joint forward kinematics pipeline.
// Pipelined from the start beat to the done beat; one beat accepted every cycle.
// Depth is set by the 28-stage CORDIC chain plus angle sum, fold, unfold, multiply, sum.
// busy stays low; the receiver cannot stall, so done and tip_x/tip_y show for one cycle.
// Reset clears all in-flight valids and restores the link lengths to 1.0, 0.5 and 0.25.
module planar_three_link_forward_kinematics
    import pfk_pkg::*;
#(
    parameter int ANGLE_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [ANGLE_BITS-1:0]  angle_base,
    input  logic [ANGLE_BITS-1:0]  angle_shoulder,
    input  logic [ANGLE_BITS-1:0]  angle_elbow,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [LENGTH_W-1:0]    cfg_data,
    output logic                   done,
    output logic signed [OUT_W-1:0] tip_x,
    output logic signed [OUT_W-1:0] tip_y
);

    localparam int LATENCY = 1 + 1 + CORDIC_STAGES + 1 + 2;

    logic [ANGLE_BITS-1:0] a1_reg;
    logic [ANGLE_BITS-1:0] a12_reg;
    logic [ANGLE_BITS-1:0] a123_reg;
    logic [ANGLE_BITS-1:0] a12_next;
    logic [ANGLE_BITS-1:0] a123_next;
    logic [LATENCY-1:0]    valid_reg;
    length_t               length_base_reg;
    length_t               length_shoulder_reg;
    length_t               length_elbow_reg;
    unit_t                 units   [3];
    length_t               lengths [3];

    assign busy = 1'b0;

    assign a12_next  = angle_base + angle_shoulder;
    assign a123_next = a12_next + angle_elbow;

    always_ff @(posedge clk)
    begin
        a1_reg   <= angle_base;
        a12_reg  <= a12_next;
        a123_reg <= a123_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[LATENCY-2:0], start & ~busy};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_base_reg     <= LENGTH_BASE_RESET;
            length_shoulder_reg <= LENGTH_SHOULDER_RESET;
            length_elbow_reg    <= LENGTH_ELBOW_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_LENGTH_BASE:     length_base_reg     <= cfg_data;
                REG_LENGTH_SHOULDER: length_shoulder_reg <= cfg_data;
                REG_LENGTH_ELBOW:    length_elbow_reg    <= cfg_data;
                default:             ;
            endcase
        end
    end

    pfk_sincos #(
        .ANGLE_BITS(ANGLE_BITS)
    ) u_sincos_base (
        .clk  (clk),
        .angle(a1_reg),
        .unit (units[0])
    );

    pfk_sincos #(
        .ANGLE_BITS(ANGLE_BITS)
    ) u_sincos_shoulder (
        .clk  (clk),
        .angle(a12_reg),
        .unit (units[1])
    );

    pfk_sincos #(
        .ANGLE_BITS(ANGLE_BITS)
    ) u_sincos_elbow (
        .clk  (clk),
        .angle(a123_reg),
        .unit (units[2])
    );

    assign lengths[0] = length_base_reg;
    assign lengths[1] = length_shoulder_reg;
    assign lengths[2] = length_elbow_reg;

    pfk_combine u_combine (
        .clk    (clk),
        .units  (units),
        .lengths(lengths),
        .tip_x  (tip_x),
        .tip_y  (tip_y)
    );

    assign done = valid_reg[LATENCY-1];

endmodule

>>> tb/sv/planar_three_link_forward_kinematics_tb.sv
// Self-checking testbench for the planar three-joint forward kinematics block.
module planar_three_link_forward_kinematics_tb;
    import pfk_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ANGLE_W = 16;
    localparam int LATENCY = 33;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_PHASES = 12;
    localparam int SETS_PER_PHASE = 152;
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 2'd3;
    localparam longint UNIT_GAIN = 64'sd652032874;
    localparam longint HALF_OUT_LSB = 64'sd536870912;
    localparam longint ARCTAN [28] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005
    };

    typedef logic [ANGLE_W-1:0] angle_t;

    typedef struct packed {
        angle_t base;
        angle_t shoulder;
        angle_t elbow;
    } joint_set_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } tip_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    angle_t angle_base = '0;
    angle_t angle_shoulder = '0;
    angle_t angle_elbow = '0;
    logic cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [LENGTH_W-1:0] cfg_data = '0;
    logic done;
    coord_t tip_x;
    coord_t tip_y;

    joint_set_t joint_sets [$];
    tip_t expected_tips [$];
    joint_set_t next_set;
    tip_t want;
    longint link_len [3];
    int sender_idle_pct = 0;
    int errors = 0;
    int quiet_cycles = 0;

    planar_three_link_forward_kinematics u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .angle_base     (angle_base),
        .angle_shoulder (angle_shoulder),
        .angle_elbow    (angle_elbow),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .done           (done),
        .tip_x          (tip_x),
        .tip_y          (tip_y)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void unit_vector(input logic [31:0] ang, output longint c,
                                        output longint s);
        longint x;
        longint y;
        longint z;
        longint nx;
        logic flip;
        flip = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
        if (flip)
            ang = ang ^ 32'h8000_0000;
        x = UNIT_GAIN;
        y = 0;
        z = longint'($signed(ang));
        for (int i = 0; i < 28; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - ARCTAN[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + ARCTAN[i];
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic coord_t round_coord(input longint acc);
        longint r;
        r = (acc + HALF_OUT_LSB) >>> 30;
        return r[OUT_W-1:0];
    endfunction

    function automatic tip_t predict_tip(input angle_t a_base, input angle_t a_shoulder,
                                         input angle_t a_elbow);
        angle_t sum2;
        angle_t sum3;
        longint c1, s1, c2, s2, c3, s3;
        tip_t tip;
        sum2 = a_base + a_shoulder;
        sum3 = sum2 + a_elbow;
        unit_vector({a_base, 16'h0}, c1, s1);
        unit_vector({sum2, 16'h0}, c2, s2);
        unit_vector({sum3, 16'h0}, c3, s3);
        tip.x = round_coord(link_len[0] * c1 + link_len[1] * c2 + link_len[2] * c3);
        tip.y = round_coord(link_len[0] * s1 + link_len[1] * s2 + link_len[2] * s3);
        return tip;
    endfunction

    function automatic angle_t pick_angle();
        angle_t a;
        if ($urandom_range(7) == 0)
            a = angle_t'($urandom_range(3) * 16'h4000 + $urandom_range(4) - 2);
        else
            a = angle_t'($urandom_range(16'hFFFF));
        return a;
    endfunction

    function automatic logic [LENGTH_W-1:0] pick_length();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            default: return LENGTH_W'($urandom_range(16'hFFFF));
        endcase
    endfunction

    task automatic queue_set(input angle_t b, input angle_t s, input angle_t e);
        joint_set_t js;
        js.base = b;
        js.shoulder = s;
        js.elbow = e;
        joint_sets.push_back(js);
    endtask

    task automatic write_length(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [LENGTH_W-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_LENGTH_BASE: link_len[0] = longint'(value);
            REG_LENGTH_SHOULDER: link_len[1] = longint'(value);
            REG_LENGTH_ELBOW: link_len[2] = longint'(value);
            default: ;
        endcase
    endtask

    task automatic drain();
        while (joint_sets.size() != 0 || start || expected_tips.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
                expected_tips.push_back(predict_tip(angle_base, angle_shoulder, angle_elbow));
            if (!start || !busy)
            begin
                if (joint_sets.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    next_set = joint_sets.pop_front();
                    start <= 1'b1;
                    angle_base <= next_set.base;
                    angle_shoulder <= next_set.shoulder;
                    angle_elbow <= next_set.elbow;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_tips.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat tip_x=%0d tip_y=%0d", $time, tip_x, tip_y);
            end
            else
            begin
                want = expected_tips.pop_front();
                if (tip_x !== want.x)
                begin
                    errors++;
                    $display("%0t: tip_x expected %0d actual %0d", $time, want.x, tip_x);
                end
                if (tip_y !== want.y)
                begin
                    errors++;
                    $display("%0t: tip_y expected %0d actual %0d", $time, want.y, tip_y);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || cfg_write)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress, %0d beats still expected", $time, expected_tips.size());
            $display("planar_three_link_forward_kinematics regression: fail");
            $finish;
        end
    end

    initial
    begin
        link_len[0] = longint'(LENGTH_BASE_RESET);
        link_len[1] = longint'(LENGTH_SHOULDER_RESET);
        link_len[2] = longint'(LENGTH_ELBOW_RESET);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        queue_set(16'h0000, 16'h0000, 16'h0000);
        queue_set(16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_set(16'h4000, 16'h0000, 16'h0000);
        queue_set(16'h8000, 16'h0000, 16'h0000);
        queue_set(16'hC000, 16'h0000, 16'h0000);
        queue_set(16'h3FFF, 16'h4001, 16'h7FFF);
        queue_set(16'h8001, 16'hBFFF, 16'hC001);
        queue_set(16'h8000, 16'h8000, 16'h8000);
        queue_set(16'hFFFF, 16'h0001, 16'h0000);
        queue_set(16'h2000, 16'h2000, 16'h2000);
        queue_set(16'hAAAA, 16'h5555, 16'hAAAA);
        queue_set(16'h5555, 16'hAAAA, 16'h5555);
        queue_set(16'hE000, 16'h4000, 16'hC000);
        drain();

        write_length(REG_LENGTH_BASE, '1);
        write_length(REG_LENGTH_SHOULDER, '1);
        write_length(REG_LENGTH_ELBOW, '1);
        queue_set(16'h0000, 16'h0000, 16'h0000);
        queue_set(16'h8000, 16'h0000, 16'h0000);
        queue_set(16'h4000, 16'h0000, 16'h0000);
        queue_set(16'hC000, 16'h0000, 16'h0000);
        queue_set(16'h2000, 16'hFFFF, 16'h0001);
        drain();

        write_length(REG_LENGTH_BASE, '0);
        write_length(REG_LENGTH_SHOULDER, '0);
        write_length(REG_LENGTH_ELBOW, '0);
        write_length(REG_UNMAPPED, '1);
        queue_set(16'h0000, 16'h0000, 16'h0000);
        queue_set(16'h4000, 16'h1234, 16'hFEDC);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p % 4)
                0: sender_idle_pct = 0;
                1: sender_idle_pct = 86;
                2: sender_idle_pct = 0;
                default: sender_idle_pct = 26;
            endcase
            write_length(REG_LENGTH_BASE, pick_length());
            write_length(REG_LENGTH_SHOULDER, pick_length());
            write_length(REG_LENGTH_ELBOW, pick_length());
            if ($urandom_range(2) == 0)
                write_length(REG_UNMAPPED, LENGTH_W'($urandom_range(16'hFFFF)));
            for (int n = 0; n < SETS_PER_PHASE; n++)
                queue_set(pick_angle(), pick_angle(), pick_angle());
            drain();
        end

        if (errors == 0)
            $display("planar_three_link_forward_kinematics regression: pass");
        else
            $display("planar_three_link_forward_kinematics regression: fail");
        $finish;
    end

endmodule

>>> planar_three_link_forward_kinematics.f
hdl/pfk_pkg.sv
hdl/pfk_cordic_stage.sv
hdl/pfk_sincos.sv
hdl/pfk_combine.sv
hdl/planar_three_link_forward_kinematics.sv
tb/sv/planar_three_link_forward_kinematics_tb.sv
